// ===== hdl/sscr_pkg.sv =====
`default_nettype none

package sscr_pkg;

   // Segment modes, same encoding on input and output
   typedef enum logic [1:0] {
      MODE_STOP       = 2'd0,
      MODE_CORNER_IN  = 2'd1,
      MODE_CORNER_OUT = 2'd2,
      MODE_STRAIGHT   = 2'd3
   } mode_type;

   // Register indexes on the csr channel
   typedef enum logic [2:0] {
      REG_STRAIGHT_SPEED   = 3'd0,
      REG_CORNER_IN_SPEED  = 3'd1,
      REG_CORNER_OUT_SPEED = 3'd2,
      REG_CONTROL_PERIOD   = 3'd3,
      REG_ACCEL_PERIOD     = 3'd4,
      REG_BRAKE_PERIOD     = 3'd5,
      REG_ACCEL_STEP       = 3'd6,
      REG_BRAKE_STEP       = 3'd7
   } reg_index_type;

   localparam int unsigned SPEED_W = 8;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned DATA_W  = 16;

   localparam logic [TICK_W-1:0]  TICK_MAX = {TICK_W{1'b1}};
   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   // Reset values of the registers
   localparam logic [SPEED_W-1:0] STRAIGHT_SPEED_RST   = 8'd29;
   localparam logic [SPEED_W-1:0] CORNER_IN_SPEED_RST  = 8'd7;
   localparam logic [SPEED_W-1:0] CORNER_OUT_SPEED_RST = 8'd10;
   localparam logic [TICK_W-1:0]  CONTROL_PERIOD_RST   = 16'd10;
   localparam logic [TICK_W-1:0]  ACCEL_PERIOD_RST     = 16'd50;
   localparam logic [TICK_W-1:0]  BRAKE_PERIOD_RST     = 16'd10;
   localparam logic [SPEED_W-1:0] ACCEL_STEP_RST       = 8'd1;
   localparam logic [SPEED_W-1:0] BRAKE_STEP_RST       = 8'd3;

   typedef struct packed {
      logic [SPEED_W-1:0] straight_speed;
      logic [SPEED_W-1:0] corner_in_speed;
      logic [SPEED_W-1:0] corner_out_speed;
      logic [TICK_W-1:0]  control_period;
      logic [TICK_W-1:0]  accel_period;
      logic [TICK_W-1:0]  brake_period;
      logic [SPEED_W-1:0] accel_step;
      logic [SPEED_W-1:0] brake_step;
   } cfg_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_command;
      logic               speed_updated;
      logic [1:0]         mode_now;
   } result_type;

   // Saturating tick increment
   function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] t);
      tick_inc = (t == TICK_MAX) ? TICK_MAX : t + TICK_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sscr_if.sv =====
`default_nettype none

// Tick item channel
interface sscr_req_if;
   logic       valid;
   logic       ready;
   logic       mode_write;
   logic [1:0] new_mode;
   logic       line_lost;

   modport source (output valid, mode_write, new_mode, line_lost, input ready);
   modport sink   (input valid, mode_write, new_mode, line_lost, output ready);
endinterface

// Result item channel
interface sscr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] speed_command;
   logic       speed_updated;
   logic [1:0] mode_now;

   modport source (output valid, speed_command, speed_updated, mode_now, input ready);
   modport sink   (input valid, speed_command, speed_updated, mode_now, output ready);
endinterface

// Register write channel
interface sscr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sscr_csr.sv =====
`default_nettype none

module sscr_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [sscr_pkg::INDEX_W-1:0] wr_index,
   input  wire logic [sscr_pkg::DATA_W-1:0]  wr_data,
   output sscr_pkg::cfg_type                 cfg
);

   sscr_pkg::cfg_type cfg_ff;
   sscr_pkg::cfg_type cfg_in;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sscr_pkg::reg_index_type'(wr_index))
            sscr_pkg::REG_STRAIGHT_SPEED:
               cfg_in.straight_speed = wr_data[sscr_pkg::SPEED_W-1:0];
            sscr_pkg::REG_CORNER_IN_SPEED:
               cfg_in.corner_in_speed = wr_data[sscr_pkg::SPEED_W-1:0];
            sscr_pkg::REG_CORNER_OUT_SPEED:
               cfg_in.corner_out_speed = wr_data[sscr_pkg::SPEED_W-1:0];
            sscr_pkg::REG_CONTROL_PERIOD:
               cfg_in.control_period = wr_data[sscr_pkg::TICK_W-1:0];
            sscr_pkg::REG_ACCEL_PERIOD:
               cfg_in.accel_period = wr_data[sscr_pkg::TICK_W-1:0];
            sscr_pkg::REG_BRAKE_PERIOD:
               cfg_in.brake_period = wr_data[sscr_pkg::TICK_W-1:0];
            sscr_pkg::REG_ACCEL_STEP:
               cfg_in.accel_step = wr_data[sscr_pkg::SPEED_W-1:0];
            sscr_pkg::REG_BRAKE_STEP:
               cfg_in.brake_step = wr_data[sscr_pkg::SPEED_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.straight_speed   <= sscr_pkg::STRAIGHT_SPEED_RST;
         cfg_ff.corner_in_speed  <= sscr_pkg::CORNER_IN_SPEED_RST;
         cfg_ff.corner_out_speed <= sscr_pkg::CORNER_OUT_SPEED_RST;
         cfg_ff.control_period   <= sscr_pkg::CONTROL_PERIOD_RST;
         cfg_ff.accel_period     <= sscr_pkg::ACCEL_PERIOD_RST;
         cfg_ff.brake_period     <= sscr_pkg::BRAKE_PERIOD_RST;
         cfg_ff.accel_step       <= sscr_pkg::ACCEL_STEP_RST;
         cfg_ff.brake_step       <= sscr_pkg::BRAKE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/sscr_core.sv =====
`default_nettype none

module sscr_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              mode_write,
   input  wire logic [1:0]        new_mode,
   input  wire logic              line_lost,
   input  wire sscr_pkg::cfg_type cfg,
   output sscr_pkg::result_type   result
);

   localparam int unsigned SW = sscr_pkg::SPEED_W;
   localparam int unsigned TW = sscr_pkg::TICK_W;

   sscr_pkg::mode_type mode_ff, mode_in;
   logic [SW-1:0]      speed_ff, speed_in;
   logic [TW-1:0]      ctrl_ticks_ff, ctrl_ticks_in;
   logic [TW-1:0]      accel_ticks_ff, accel_ticks_in;
   logic [TW-1:0]      brake_ticks_ff, brake_ticks_in;

   logic [TW-1:0]      ctrl_inc, accel_inc, brake_inc;
   sscr_pkg::mode_type mode_sel;
   logic [SW-1:0]      target;
   logic [SW-1:0]      speed_braked;
   logic               brake_ok, accel_ok, fire;
   logic [SW:0]        accel_sum;
   logic [SW-1:0]      speed_accel_base;
   logic               ramp_mode;

   assign ctrl_inc  = sscr_pkg::tick_inc(ctrl_ticks_ff);
   assign accel_inc = sscr_pkg::tick_inc(accel_ticks_ff);
   assign brake_inc = sscr_pkg::tick_inc(brake_ticks_ff);

   assign mode_sel = mode_write ? sscr_pkg::mode_type'(new_mode) : mode_ff;
   assign fire     = ctrl_inc > cfg.control_period;
   assign brake_ok = brake_inc > cfg.brake_period;
   assign accel_ok = accel_inc > cfg.accel_period;

   // Target speed for the selected segment
   always_comb begin
      unique case (mode_sel)
         sscr_pkg::MODE_CORNER_IN:  target = cfg.corner_in_speed;
         sscr_pkg::MODE_CORNER_OUT: target = cfg.corner_out_speed;
         sscr_pkg::MODE_STRAIGHT:   target = cfg.straight_speed;
         default:                   target = '0;
      endcase
   end

   assign ramp_mode = (mode_sel == sscr_pkg::MODE_CORNER_IN) ||
                      (mode_sel == sscr_pkg::MODE_CORNER_OUT);

   // Brake step, floors at zero (corner modes only)
   assign speed_braked = (speed_ff > cfg.brake_step) ? speed_ff - cfg.brake_step : '0;
   assign speed_accel_base = (ramp_mode && speed_ff > target && brake_ok) ?
                             speed_braked : speed_ff;
   assign accel_sum = {1'b0, speed_accel_base} + {1'b0, cfg.accel_step};

   // Next state for one tick
   always_comb begin
      mode_in        = mode_sel;
      speed_in       = speed_ff;
      ctrl_ticks_in  = ctrl_inc;
      accel_ticks_in = accel_inc;
      brake_ticks_in = brake_inc;
      if (fire) begin
         ctrl_ticks_in = '0;
         unique case (mode_sel)
            sscr_pkg::MODE_STOP: begin
               speed_in = '0;
            end
            sscr_pkg::MODE_CORNER_IN, sscr_pkg::MODE_CORNER_OUT: begin
               if (speed_ff > target && brake_ok) begin
                  brake_ticks_in = '0;
               end
               speed_in = speed_accel_base;
               if (speed_accel_base < target && accel_ok) begin
                  accel_ticks_in = '0;
                  speed_in = accel_sum[SW] ? sscr_pkg::SPEED_MAX : accel_sum[SW-1:0];
               end
            end
            sscr_pkg::MODE_STRAIGHT: begin
               if (line_lost) begin
                  mode_in = sscr_pkg::MODE_STOP;
               end else if (speed_ff < target && accel_ok) begin
                  accel_ticks_in = '0;
                  speed_in = accel_sum[SW] ? sscr_pkg::SPEED_MAX : accel_sum[SW-1:0];
               end
            end
            default: speed_in = speed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= sscr_pkg::MODE_STOP;
         speed_ff       <= '0;
         ctrl_ticks_ff  <= '0;
         accel_ticks_ff <= '0;
         brake_ticks_ff <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         speed_ff       <= speed_in;
         ctrl_ticks_ff  <= ctrl_ticks_in;
         accel_ticks_ff <= accel_ticks_in;
         brake_ticks_ff <= brake_ticks_in;
      end
   end

   assign result.speed_command = speed_in;
   assign result.speed_updated = fire;
   assign result.mode_now      = mode_in;

endmodule

`default_nettype wire

// ===== hdl/sscr_out.sv =====
`default_nettype none

module sscr_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire sscr_pkg::result_type push_data,
   output logic                      can_push,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sscr_pkg::result_type      out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sscr_pkg::result_type main_ff, main_in;
   sscr_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop = main_valid_ff && out_ready;

   // Two-deep result queue: main register drives the port, skid catches a stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         main_valid_in = skid_valid_ff;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

// ===== hdl/segment_speed_ramp_controller.sv =====
// Segment speed ramp controller: slew-rate limited motor speed.
// req : one item per 1 ms tick (mode_write, new_mode, line_lost).
// rsp : one item per tick (speed_command, speed_updated, mode_now).
// csr : register writes, index 0..7, always ready; write only while idle.
// A tick's result is registered into the result queue, which drives rsp.
// Throughput: one tick per clock while req.ready is high; the whole update
// is a single pass of compares and 8-bit adds on the state registers.
// The result side is two entries deep: while rsp stalls the block still
// takes one further tick, then drops req.ready until rsp drains.
// Reset (synchronous, active high) sets mode to stop, speed and all tick
// counters to zero, registers to their defaults and empties the result
// queue. No clearing pass is needed.
`default_nettype none

module segment_speed_ramp_controller (
   input  wire logic clock,
   input  wire logic reset,
   sscr_req_if.sink  req,
   sscr_rsp_if.source rsp,
   sscr_csr_if.sink  csr
);

   sscr_pkg::cfg_type    cfg;
   sscr_pkg::result_type step_result;
   sscr_pkg::result_type out_data;
   logic                 accept;
   logic                 can_push;

   assign csr.ready = 1'b1;
   assign req.ready = can_push;
   assign accept    = req.valid && can_push;

   sscr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   sscr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode_write (req.mode_write),
      .new_mode   (req.new_mode),
      .line_lost  (req.line_lost),
      .cfg        (cfg),
      .result     (step_result)
   );

   sscr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .can_push  (can_push),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_data)
   );

   assign rsp.speed_command = out_data.speed_command;
   assign rsp.speed_updated = out_data.speed_updated;
   assign rsp.mode_now      = out_data.mode_now;

   // Skid entry is only ever used behind a full main register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("skid entry held while output register empty");

   // A tick taken during a stall fills the skid entry
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready && req.valid && req.ready |=> !req.ready)
      else $error("stalled tick not held in skid entry");

   // Draining with a full skid moves it forward and frees the input
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !req.ready |=> rsp.valid && req.ready)
      else $error("skid entry not moved forward on drain");

endmodule

`default_nettype wire
